/* hdl/rotation_matrix_to_quaternion_top_defines.svh */
// ----------------------------------------------------------------------------
// rotation matrix to quaternion: assertion macros
// checks are compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`ifndef SYNTH
`define RMQ_CHECK(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rmq check failed");
`define RMQ_CHECK_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rmq next-cycle check failed");
`else
`define RMQ_CHECK(label, ante, cons)
`define RMQ_CHECK_NEXT(label, ante, cons)
`endif
`endif

/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// widths, request/response types and pipeline tokens for the converter
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ELEM_W    = 16;
   localparam int DIFF_W    = ELEM_W + 1;
   // positive square-root argument fits in A_UW unsigned bits
   localparam int A_UW      = ((FRAC_BITS > ELEM_W + 1) ? FRAC_BITS : ELEM_W + 1) + 1;
   localparam int A_SW      = A_UW + 1;
   localparam int ROOT_W    = (A_UW + FRAC_BITS + 1) / 2;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SREM_W    = ROOT_W + 2;
   localparam int DEN_W     = ROOT_W + 1;
   localparam int DREM_W    = ROOT_W + 2;
   localparam int QUO_W     = DIFF_W + FRAC_BITS;
   localparam int LANES     = 3;
   localparam int COMPS     = 4;
   localparam int ELEMS     = 9;

   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_DIAG0 = 2'd1,
      BR_DIAG1 = 2'd2,
      BR_DIAG2 = 2'd3
   } branch_type;

   typedef struct packed {
      logic [ELEMS-1:0][ELEM_W-1:0] elem;   // index row*3 + col
   } req_type;

   typedef struct packed {
      branch_type                    branch;
      logic                          degen;
      logic [LANES-1:0][DIFF_W-1:0]  num;
      logic [RAD_W-1:0]              rad;
      logic [SREM_W-1:0]             rem;
      logic [ROOT_W-1:0]             root;
   } sq_type;

   typedef struct packed {
      branch_type                    branch;
      logic                          degen;
      logic [ROOT_W-1:0]             root;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0][DREM_W-1:0]  rem;
      logic [LANES-1:0][QUO_W-1:0]   quo;
      logic [LANES-1:0][QUO_W-1:0]   mag;
   } dv_type;

   typedef struct packed {
      logic [COMPS-1:0][ELEM_W-1:0]  quat;  // x, y, z, w
      branch_type                    branch;
      logic                          degen;
   } rsp_type;

endpackage

/* hdl/rmq_channels.sv */
// ----------------------------------------------------------------------------
// rmq channels
// valid/ready request and response interfaces
// ----------------------------------------------------------------------------
interface rmq_req_if import rmq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] elem_r0c0;
   logic signed [ELEM_W-1:0] elem_r0c1;
   logic signed [ELEM_W-1:0] elem_r0c2;
   logic signed [ELEM_W-1:0] elem_r1c0;
   logic signed [ELEM_W-1:0] elem_r1c1;
   logic signed [ELEM_W-1:0] elem_r1c2;
   logic signed [ELEM_W-1:0] elem_r2c0;
   logic signed [ELEM_W-1:0] elem_r2c1;
   logic signed [ELEM_W-1:0] elem_r2c2;

   modport source (output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                   elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, input ready);
   modport sink (input valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                 elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, output ready);
endinterface

interface rmq_rsp_if import rmq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] quat_x;
   logic signed [ELEM_W-1:0] quat_y;
   logic signed [ELEM_W-1:0] quat_z;
   logic signed [ELEM_W-1:0] quat_w;
   logic [1:0]               branch_taken;
   logic                     degenerate;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
                   input ready);
   modport sink (input valid, quat_x, quat_y, quat_z, quat_w, branch_taken, degenerate,
                 output ready);
endinterface

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// branch choice, square-root argument and the three numerators
// ----------------------------------------------------------------------------
module rmq_front import rmq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output sq_type  out_data
);

   localparam logic signed [A_SW-1:0] ONE_A = A_SW'(1) << FRAC_BITS;

   logic                     valid_ff;
   sq_type                   data_ff;
   sq_type                   data_in;
   logic signed [A_SW-1:0]   t00, t11, t22, tr, a;
   branch_type               br;

   function automatic logic [DIFF_W-1:0] dsub(logic [ELEM_W-1:0] p, logic [ELEM_W-1:0] q);
      return DIFF_W'($signed(p)) - DIFF_W'($signed(q));
   endfunction

   function automatic logic [DIFF_W-1:0] dadd(logic [ELEM_W-1:0] p, logic [ELEM_W-1:0] q);
      return DIFF_W'($signed(p)) + DIFF_W'($signed(q));
   endfunction

   // t(i,j) = m(j,i); element index is row*3 + col of the given matrix
   always_comb begin
      t00 = A_SW'($signed(in_data.elem[0]));
      t11 = A_SW'($signed(in_data.elem[4]));
      t22 = A_SW'($signed(in_data.elem[8]));
      tr  = t00 + t11 + t22;
      if (tr > 0) begin
         br = BR_TRACE;
         a  = ONE_A + tr;
      end else if (t00 > t11 && t00 > t22) begin
         br = BR_DIAG0;
         a  = ONE_A + t00 - t11 - t22;
      end else if (t11 > t22) begin
         br = BR_DIAG1;
         a  = ONE_A + t11 - t00 - t22;
      end else begin
         br = BR_DIAG2;
         a  = ONE_A + t22 - t00 - t11;
      end

      data_in        = '0;
      data_in.branch = br;
      data_in.degen  = a[A_SW-1] || (a == '0);
      data_in.rad    = data_in.degen ? '0 : (RAD_W'(a[A_UW-1:0]) << FRAC_BITS);

      // lanes fill the non-diagonal slots of x, y, z, w in order
      case (br)
         BR_TRACE: begin
            data_in.num[0] = dsub(in_data.elem[5], in_data.elem[7]);
            data_in.num[1] = dsub(in_data.elem[6], in_data.elem[2]);
            data_in.num[2] = dsub(in_data.elem[1], in_data.elem[3]);
         end
         BR_DIAG0: begin
            data_in.num[0] = dadd(in_data.elem[3], in_data.elem[1]);
            data_in.num[1] = dadd(in_data.elem[6], in_data.elem[2]);
            data_in.num[2] = dsub(in_data.elem[5], in_data.elem[7]);
         end
         BR_DIAG1: begin
            data_in.num[0] = dadd(in_data.elem[3], in_data.elem[1]);
            data_in.num[1] = dadd(in_data.elem[7], in_data.elem[5]);
            data_in.num[2] = dsub(in_data.elem[6], in_data.elem[2]);
         end
         default: begin
            data_in.num[0] = dadd(in_data.elem[6], in_data.elem[2]);
            data_in.num[1] = dadd(in_data.elem[7], in_data.elem[5]);
            data_in.num[2] = dsub(in_data.elem[1], in_data.elem[3]);
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/rmq_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one result bit of the integer square root per cell
// ----------------------------------------------------------------------------
module rmq_sqrt_cell import rmq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  sq_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output sq_type out_data
);

   logic              valid_ff;
   sq_type            data_ff;
   sq_type            data_in;
   logic [SREM_W-1:0] rem_sh;
   logic [SREM_W-1:0] trial;
   logic              ge;

   always_comb begin
      rem_sh       = {in_data.rem[SREM_W-3:0], in_data.rad[RAD_W-1 -: 2]};
      trial        = {in_data.root, 2'b01};
      ge           = (rem_sh >= trial);
      data_in      = in_data;
      data_in.rad  = in_data.rad << 2;
      data_in.rem  = ge ? (rem_sh - trial) : rem_sh;
      data_in.root = {in_data.root[ROOT_W-2:0], ge};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/rmq_div_cell.sv */
// ----------------------------------------------------------------------------
// rmq_div_cell
// one quotient bit per cell for each of the three restoring divide lanes
// ----------------------------------------------------------------------------
module rmq_div_cell import rmq_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  dv_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output dv_type out_data
);

   logic              valid_ff;
   dv_type            data_ff;
   dv_type            data_in;
   logic [DREM_W-1:0] den;
   logic [DREM_W-1:0] rem_sh;
   logic              ge;

   always_comb begin
      // divisor is twice the root
      den     = DREM_W'({in_data.root, 1'b0});
      data_in = in_data;
      rem_sh  = '0;
      ge      = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         rem_sh         = {in_data.rem[i][DREM_W-2:0], in_data.mag[i][QUO_W-1]};
         ge             = (rem_sh >= den);
         data_in.rem[i] = ge ? (rem_sh - den) : rem_sh;
         data_in.quo[i] = {in_data.quo[i][QUO_W-2:0], ge};
         data_in.mag[i] = in_data.mag[i] << 1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/rmq_pack.sv */
// ----------------------------------------------------------------------------
// rmq_pack
// sign restore, saturation, slot placement and the response register
// ----------------------------------------------------------------------------
module rmq_pack import rmq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dv_type  in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   localparam int SQ_W = QUO_W + 1;
   localparam logic signed [SQ_W-1:0] MAX_Q = SQ_W'(2**(ELEM_W-1) - 1);
   localparam logic signed [SQ_W-1:0] MIN_Q = -SQ_W'(2**(ELEM_W-1));

   logic                         valid_ff;
   rsp_type                      data_ff;
   rsp_type                      data_in;
   logic [LANES-1:0][ELEM_W-1:0] lane_q;
   logic signed [SQ_W-1:0]       sq;
   logic [ELEM_W-1:0]            diag;
   logic [ROOT_W-1:0]            half;
   logic [1:0]                   dslot;

   always_comb begin
      sq = '0;
      for (int i = 0; i < LANES; i++) begin
         sq = in_data.neg[i] ? -$signed({1'b0, in_data.quo[i]})
                             : $signed({1'b0, in_data.quo[i]});
         if (sq > MAX_Q) begin
            lane_q[i] = MAX_Q[ELEM_W-1:0];
         end else if (sq < MIN_Q) begin
            lane_q[i] = MIN_Q[ELEM_W-1:0];
         end else begin
            lane_q[i] = sq[ELEM_W-1:0];
         end
      end

      half = in_data.root >> 1;
      if (ROOT_W'(half) > ROOT_W'(MAX_Q[ELEM_W-1:0])) begin
         diag = MAX_Q[ELEM_W-1:0];
      end else begin
         diag = ELEM_W'(half);
      end

      case (in_data.branch)
         BR_TRACE: dslot = 2'd3;
         BR_DIAG0: dslot = 2'd0;
         BR_DIAG1: dslot = 2'd1;
         default:  dslot = 2'd2;
      endcase

      data_in        = '0;
      data_in.branch = in_data.branch;
      data_in.degen  = in_data.degen;
      for (int k = 0; k < COMPS; k++) begin
         if (in_data.degen) begin
            data_in.quat[k] = '0;
         end else if (k == int'(dslot)) begin
            data_in.quat[k] = diag;
         end else if (k < int'(dslot)) begin
            data_in.quat[k] = lane_q[k];
         end else begin
            data_in.quat[k] = lane_q[k-1];
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* hdl/rotation_matrix_to_quaternion_top.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// shepperd conversion of a fixed-point 3x3 rotation matrix to a quaternion
// ----------------------------------------------------------------------------
//   channel   dir   handshake      payload
//   req_if    in    valid/ready    elem_r0c0 .. elem_r2c2, signed 16 bit
//   rsp_if    out   valid/ready    quat_x/y/z/w, branch_taken, degenerate
//
// one request per cycle unless the chain is full behind a held response; a request
// passes the front register, the row of square-root cells (one root bit each), the
// divide cells (one quotient bit each) and the pack register. every cell holds its own
// valid bit, so bubbles close up and requests keep entering while a response waits.
// synchronous reset clears the valid bits only.
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_quaternion_top_defines.svh"

module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
   input logic      clock,
   input logic      reset,
   rmq_req_if.sink  req_if,
   rmq_rsp_if.source rsp_if
);

   req_type                 req_data;
   logic [ROOT_W:0]         sq_valid;
   logic [ROOT_W:0]         sq_ready;
   sq_type [ROOT_W:0]       sq_data;
   logic [QUO_W:0]          dv_valid;
   logic [QUO_W:0]          dv_ready;
   dv_type [QUO_W:0]        dv_data;
   dv_type                  dv_head;
   logic [DIFF_W:0]         abs_w;
   rsp_type                 rsp_data;

   always_comb begin
      req_data.elem[0] = req_if.elem_r0c0;
      req_data.elem[1] = req_if.elem_r0c1;
      req_data.elem[2] = req_if.elem_r0c2;
      req_data.elem[3] = req_if.elem_r1c0;
      req_data.elem[4] = req_if.elem_r1c1;
      req_data.elem[5] = req_if.elem_r1c2;
      req_data.elem[6] = req_if.elem_r2c0;
      req_data.elem[7] = req_if.elem_r2c1;
      req_data.elem[8] = req_if.elem_r2c2;
   end

   rmq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .in_data   (req_data),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_data  (sq_data[0])
   );

   for (genvar g = 0; g < ROOT_W; g++) begin : g_sqrt
      rmq_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[g]),
         .in_ready  (sq_ready[g]),
         .in_data   (sq_data[g]),
         .out_valid (sq_valid[g+1]),
         .out_ready (sq_ready[g+1]),
         .out_data  (sq_data[g+1])
      );
   end

   // root done: set up magnitudes and signs for the divide lanes
   always_comb begin
      dv_head        = '0;
      dv_head.branch = sq_data[ROOT_W].branch;
      dv_head.degen  = sq_data[ROOT_W].degen;
      dv_head.root   = sq_data[ROOT_W].root;
      abs_w          = '0;
      for (int i = 0; i < LANES; i++) begin
         dv_head.neg[i] = sq_data[ROOT_W].num[i][DIFF_W-1];
         abs_w = sq_data[ROOT_W].num[i][DIFF_W-1]
               ? -{sq_data[ROOT_W].num[i][DIFF_W-1], sq_data[ROOT_W].num[i]}
               : {sq_data[ROOT_W].num[i][DIFF_W-1], sq_data[ROOT_W].num[i]};
         dv_head.mag[i] = QUO_W'(abs_w[DIFF_W-1:0]) << FRAC_BITS;
      end
   end
   assign dv_data[0]       = dv_head;
   assign dv_valid[0]      = sq_valid[ROOT_W];
   assign sq_ready[ROOT_W] = dv_ready[0];

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      rmq_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_ready  (dv_ready[g]),
         .in_data   (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_ready (dv_ready[g+1]),
         .out_data  (dv_data[g+1])
      );
   end

   rmq_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid[QUO_W]),
      .in_ready  (dv_ready[QUO_W]),
      .in_data   (dv_data[QUO_W]),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.quat_x       = rsp_data.quat[0];
   assign rsp_if.quat_y       = rsp_data.quat[1];
   assign rsp_if.quat_z       = rsp_data.quat[2];
   assign rsp_if.quat_w       = rsp_data.quat[3];
   assign rsp_if.branch_taken = rsp_data.branch;
   assign rsp_if.degenerate   = rsp_data.degen;

   // degenerate response carries a zero quaternion
   `RMQ_CHECK(a_degen_zero, rsp_if.valid && rsp_if.degenerate, rsp_if.quat_x == '0 && rsp_if.quat_y == '0 && rsp_if.quat_z == '0 && rsp_if.quat_w == '0)
   // trace branch never has a non-positive argument
   `RMQ_CHECK(a_trace_nondegen, rsp_if.valid && rsp_if.degenerate, rsp_if.branch_taken != BR_TRACE)
   // the input only stalls when the whole chain is full behind a held response
   `RMQ_CHECK(a_stall_source, !req_if.ready, rsp_if.valid && !rsp_if.ready)
   // a taken response with nothing behind it leaves the output stage empty
   `RMQ_CHECK_NEXT(a_drain, rsp_if.valid && rsp_if.ready && !dv_valid[QUO_W], !rsp_if.valid)

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// rotation matrix to quaternion testbench
// drives matrices through the request channel and checks every response
// field against a fixed-point model of the shepperd conversion
// ----------------------------------------------------------------------------
module testbench;
   import rmq_pkg::*;

   typedef struct {
      logic signed [15:0] m [9];
   } matrix_type;

   typedef struct packed {
      logic signed [15:0] qx, qy, qz, qw;
      logic [1:0]         br;
      logic               degen;
   } quat_type;

   typedef struct {
      matrix_type mat;
      bit         known;
      quat_type   quat;
   } vector_type;

   localparam int LATENCY   = 2 + ROOT_W + QUO_W;
   localparam int IDLE_MAX  = 20000;
   localparam int RAND_ITEMS = 450;
   localparam logic signed [15:0] P1 = 16'sd16384;
   localparam logic signed [15:0] N1 = -16'sd16384;

   logic clock;
   logic reset;
   rmq_req_if req_if ();
   rmq_rsp_if rsp_if ();

   rotation_matrix_to_quaternion_top DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if.sink),
      .rsp_if(rsp_if.source)
   );

   quat_type   pending_quats [$];
   vector_type vectors [$];
   int  fail_count;
   int  idle_cycles;
   bit  hold_rsp;
   bit  long_hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint isqrt(longint v);
      longint res;
      longint b;
      res = 0;
      b = longint'(1) <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >>> 1) + b;
         end else begin
            res = res >>> 1;
         end
         b = b >>> 2;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint scaled_div(longint n, longint den);
      return (n * (longint'(1) <<< FRAC_BITS)) / den;
   endfunction

   // t(i,j) is the transpose: element at row j, column i of the request
   function automatic quat_type convert_matrix(matrix_type mt);
      longint t [3][3];
      longint one, tr, a, r, den, x, y, z, w;
      quat_type q;
      one = longint'(1) <<< FRAC_BITS;
      x = 0; y = 0; z = 0; w = 0;
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            t[i][j] = longint'(mt.m[j*3+i]);
      tr = t[0][0] + t[1][1] + t[2][2];
      if (tr > 0) begin
         q.br = BR_TRACE; a = one + tr;
      end else if (t[0][0] > t[1][1] && t[0][0] > t[2][2]) begin
         q.br = BR_DIAG0; a = one + t[0][0] - t[1][1] - t[2][2];
      end else if (t[1][1] > t[2][2]) begin
         q.br = BR_DIAG1; a = one + t[1][1] - t[0][0] - t[2][2];
      end else begin
         q.br = BR_DIAG2; a = one + t[2][2] - t[0][0] - t[1][1];
      end
      q.degen = (a <= 0);
      if (!q.degen) begin
         r = isqrt(a <<< FRAC_BITS);
         den = 2 * r;
         case (q.br)
            BR_TRACE: begin
               w = r >>> 1;
               x = scaled_div(t[2][1] - t[1][2], den);
               y = scaled_div(t[0][2] - t[2][0], den);
               z = scaled_div(t[1][0] - t[0][1], den);
            end
            BR_DIAG0: begin
               x = r >>> 1;
               w = scaled_div(t[2][1] - t[1][2], den);
               y = scaled_div(t[0][1] + t[1][0], den);
               z = scaled_div(t[0][2] + t[2][0], den);
            end
            BR_DIAG1: begin
               y = r >>> 1;
               w = scaled_div(t[0][2] - t[2][0], den);
               x = scaled_div(t[0][1] + t[1][0], den);
               z = scaled_div(t[1][2] + t[2][1], den);
            end
            default: begin
               z = r >>> 1;
               w = scaled_div(t[1][0] - t[0][1], den);
               x = scaled_div(t[0][2] + t[2][0], den);
               y = scaled_div(t[1][2] + t[2][1], den);
            end
         endcase
      end
      q.qx = clamp16(x); q.qy = clamp16(y); q.qz = clamp16(z); q.qw = clamp16(w);
      return q;
   endfunction

   function automatic matrix_type make_matrix(int a0, int a1, int a2, int a3, int a4,
                                              int a5, int a6, int a7, int a8);
      matrix_type mt;
      mt.m[0] = 16'(a0); mt.m[1] = 16'(a1); mt.m[2] = 16'(a2);
      mt.m[3] = 16'(a3); mt.m[4] = 16'(a4); mt.m[5] = 16'(a5);
      mt.m[6] = 16'(a6); mt.m[7] = 16'(a7); mt.m[8] = 16'(a8);
      return mt;
   endfunction

   function automatic vector_type row(matrix_type mt);
      vector_type v;
      v.mat = mt; v.known = 0;
      return v;
   endfunction

   function automatic vector_type row_known(matrix_type mt, int x, int y, int z, int w,
                                            logic [1:0] br, logic dg);
      vector_type v;
      v.mat = mt; v.known = 1;
      v.quat.qx = 16'(x); v.quat.qy = 16'(y); v.quat.qz = 16'(z); v.quat.qw = 16'(w);
      v.quat.br = br; v.quat.degen = dg;
      return v;
   endfunction

   // random matrix: fully random, all within +-16384, or small off-diagonal with random diagonal, sometimes tied
   function automatic matrix_type random_matrix();
      matrix_type mt;
      int kind;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) begin
         if (kind < 2) mt.m[i] = 16'($urandom());
         else if (kind < 4) mt.m[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
         else mt.m[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
      if (kind >= 4) begin
         for (int d = 0; d < 3; d++)
            mt.m[d*4] = 16'(int'($urandom_range(0, 32768)) - 16384);
         if (kind >= 8) mt.m[($urandom_range(0, 2))*4] = mt.m[0];
      end
      return mt;
   endfunction

   task automatic send_matrix(matrix_type mt);
      req_if.valid     <= 1'b1;
      req_if.elem_r0c0 <= mt.m[0]; req_if.elem_r0c1 <= mt.m[1]; req_if.elem_r0c2 <= mt.m[2];
      req_if.elem_r1c0 <= mt.m[3]; req_if.elem_r1c1 <= mt.m[4]; req_if.elem_r1c2 <= mt.m[5];
      req_if.elem_r2c0 <= mt.m[6]; req_if.elem_r2c1 <= mt.m[7]; req_if.elem_r2c2 <= mt.m[8];
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // queues the expected response at the accepting edge
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready) begin
         matrix_type mt;
         mt.m[0] = req_if.elem_r0c0; mt.m[1] = req_if.elem_r0c1; mt.m[2] = req_if.elem_r0c2;
         mt.m[3] = req_if.elem_r1c0; mt.m[4] = req_if.elem_r1c1; mt.m[5] = req_if.elem_r1c2;
         mt.m[6] = req_if.elem_r2c0; mt.m[7] = req_if.elem_r2c1; mt.m[8] = req_if.elem_r2c2;
         pending_quats.push_back(convert_matrix(mt));
      end
   end

   task automatic check_field(string name, int expv, int actv);
      if (expv !== actv) begin
         $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_quats.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            quat_type q;
            q = pending_quats.pop_front();
            check_field("quat_x", q.qx, rsp_if.quat_x);
            check_field("quat_y", q.qy, rsp_if.quat_y);
            check_field("quat_z", q.qz, rsp_if.quat_z);
            check_field("quat_w", q.qw, rsp_if.quat_w);
            check_field("branch_taken", q.br, rsp_if.branch_taken);
            check_field("degenerate", q.degen, rsp_if.degenerate);
         end
      end
   end

   // receiver stall pattern with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_rsp) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case ($urandom_range(0, 3))
            0: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            1: rsp_if.ready <= 1'b1;
            2: rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= (($urandom_range(0, 7)) != 0);
         endcase
      end
   end

   initial begin
      hold_rsp = 0;
      long_hold_done = 0;
      @(negedge reset);
      repeat (300) @(posedge clock);
      hold_rsp = 1;
      repeat (200) @(posedge clock);
      hold_rsp = 0;
      long_hold_done = 1;
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("rotation_matrix_to_quaternion_top regression: fail");
         $finish;
      end
   end

   initial begin
      int burst;
      fail_count = 0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.elem_r0c0 = '0; req_if.elem_r0c1 = '0; req_if.elem_r0c2 = '0;
      req_if.elem_r1c0 = '0; req_if.elem_r1c1 = '0; req_if.elem_r1c2 = '0;
      req_if.elem_r2c0 = '0; req_if.elem_r2c1 = '0; req_if.elem_r2c2 = '0;

      // identity, trace negative cases, ties, large negative diagonals and saturation
      vectors.push_back(row_known(make_matrix(P1,0,0, 0,P1,0, 0,0,P1),
                        0, 0, 0, 16384, BR_TRACE, 0));
      vectors.push_back(row_known(make_matrix(P1,0,0, 0,N1,0, 0,0,N1),
                        16384, 0, 0, 0, BR_DIAG0, 0));
      vectors.push_back(row_known(make_matrix(N1,0,0, 0,P1,0, 0,0,N1),
                        0, 16384, 0, 0, BR_DIAG1, 0));
      vectors.push_back(row_known(make_matrix(N1,0,0, 0,N1,0, 0,0,P1),
                        0, 0, 16384, 0, BR_DIAG2, 0));
      vectors.push_back(row_known(make_matrix(0,0,0, 0,0,0, 0,0,0),
                        0, 0, 8192, 0, BR_DIAG2, 0));
      vectors.push_back(row_known(make_matrix(-32768,0,0, 0,-32768,0, 0,0,-32768),
                        0, 0, 14188, 0, BR_DIAG2, 0));
      vectors.push_back(row_known(make_matrix(N1,0,0, 0,N1,0, 0,0,-32768),
                        0, 14188, 0, 0, BR_DIAG1, 0));
      vectors.push_back(row_known(make_matrix(-20000,0,0, 0,-20000,0, 0,0,-30000),
                        0, 13783, 0, 0, BR_DIAG1, 0));
      vectors.push_back(row(make_matrix(32767,32767,32767, 32767,-32768,-32768,
                                        -32768,-32768,32767)));
      vectors.push_back(row(make_matrix(-32768,32767,-32768, 32767,-32768,32767,
                                        -32768,32767,-32768)));
      vectors.push_back(row(make_matrix(100,32767,-32768, -32768,-50,32767, 32767,-32768,-50)));
      vectors.push_back(row(make_matrix(0,N1,0, P1,0,0, 0,0,P1)));
      vectors.push_back(row(make_matrix(0,P1,0, P1,0,0, 0,0,N1)));
      vectors.push_back(row(make_matrix(5,1,2, 3,5,4, 6,7,-10)));
      vectors.push_back(row(make_matrix(-5,1,2, 3,5,4, 6,7,5)));
      vectors.push_back(row(make_matrix(1,100,-200, 300,-1,400, -500,600,0)));
      vectors.push_back(row(make_matrix(11585,-11585,0, 11585,11585,0, 0,0,P1)));
      vectors.push_back(row(make_matrix(-1,0,0, 0,-1,0, 0,0,1)));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[k]) begin
         if (vectors[k].known && convert_matrix(vectors[k].mat) != vectors[k].quat) begin
            $error("directed row %0d: table entry disagrees with prediction", k);
            fail_count++;
         end
         send_matrix(vectors[k].mat);
         idle_gap($urandom_range(0, 2));
      end

      // sender stops until every response is back
      idle_gap(1);
      while (pending_quats.size() != 0) @(posedge clock);

      for (int n = 0; n < RAND_ITEMS; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && n < RAND_ITEMS; b++, n++)
            send_matrix(random_matrix());
         idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      end
      req_if.valid <= 1'b0;

      while (!long_hold_done || pending_quats.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0 && !rsp_if.valid)
         $display("rotation_matrix_to_quaternion_top regression: pass");
      else
         $display("rotation_matrix_to_quaternion_top regression: fail");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/rmq_pkg.sv
hdl/rmq_channels.sv
hdl/rmq_front.sv
hdl/rmq_sqrt_cell.sv
hdl/rmq_div_cell.sv
hdl/rmq_pack.sv
hdl/rotation_matrix_to_quaternion_top.sv
bench/testbench.sv
